// File: rtl/core/bdtt_pkg.sv
// Package for the device tracking table core: table entry type, codes, constants.
// Used by ble_device_tracking_table_core; depends on nothing.
package bdtt_pkg;

  localparam int MAX_ENTRIES = 128;
  localparam int AW          = $clog2(MAX_ENTRIES);
  localparam int CW          = $clog2(MAX_ENTRIES + 1);
  localparam int DROP        = MAX_ENTRIES / 4;

  localparam logic [9:0]  COUNT_MAX = 10'd1023;
  localparam logic [39:0] NAME_A    = 40'h48432D3033;
  localparam logic [39:0] NAME_B    = 40'h48432D3035;
  localparam logic [39:0] NAME_C    = 40'h48432D3036;

  localparam logic [15:0] RST_MIN_GAP   = 16'd50;
  localparam logic [9:0]  RST_LIMIT     = 10'd500;
  localparam logic [7:0]  RST_THIN      = 8'd80;
  localparam logic [31:0] RST_DURATION  = 32'd5000;
  localparam logic [31:0] RST_INTERVAL  = 32'd30000;
  localparam logic [31:0] RST_CLEAR_AGE = 32'd10000;
  localparam logic [31:0] RST_LEAD      = 32'd1000;

  typedef enum logic [2:0] {
    CFG_MIN_GAP   = 3'd0,
    CFG_LIMIT     = 3'd1,
    CFG_THIN      = 3'd2,
    CFG_DURATION  = 3'd3,
    CFG_INTERVAL  = 3'd4,
    CFG_CLEAR_AGE = 3'd5,
    CFG_LEAD      = 3'd6
  } cfg_idx_t;

  typedef enum logic [1:0] {
    OP_ADVERT = 2'd0,
    OP_POLL   = 2'd1,
    OP_READ   = 2'd2
  } op_t;

  typedef enum logic [3:0] {
    RS_INSERTED   = 4'd0,
    RS_UPDATED    = 4'd1,
    RS_RATE       = 4'd2,
    RS_FULL       = 4'd3,
    RS_THINNED    = 4'd4,
    RS_NO_NAME    = 4'd5,
    RS_BAD_LEN    = 4'd6,
    RS_UNKNOWN    = 4'd7,
    RS_POLL       = 4'd8,
    RS_EVICTED    = 4'd9,
    RS_READ_OK    = 4'd10,
    RS_READ_RANGE = 4'd11
  } status_t;

  typedef struct packed {
    logic [47:0] addr;
    logic [7:0]  str;
    logic [31:0] seen;
    logic [1:0]  name;
  } ent_t;

  function automatic logic ent_before(ent_t a, ent_t b, logic by_age);
    logic r;
    if (by_age) begin
      if (a.seen != b.seen) r = (a.seen < b.seen);
      else r = ($signed(a.str) < $signed(b.str));
    end else begin
      r = ($signed(a.str) > $signed(b.str));
    end
    return r;
  endfunction

endpackage

// File: rtl/core/ble_device_tracking_table_core.sv
// Device tracking table core: advert filter, strength-sorted table in one RAM, scan timer.
// Depends on bdtt_pkg. An accepted advert searches and re-sorts the table; an evicting poll
// sorts it by age and copies the kept entries down through the single RAM read port.
// One item at a time: the next beat is taken once the result sits in the output register.
// Reset is synchronous: control and configuration registers return to defaults, table is not cleared.
module ble_device_tracking_table_core
  import bdtt_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  // now_ms, has_name, name_length, name_prefix, device_address,
  // signal_strength, read_index
  input  logic [143:0] in_tdata,
  // operation
  input  logic [1:0]   in_tuser,
  output logic         out_tvalid,
  input  logic         out_tready,
  // entry_count, scanning, refresh_pending, position, entry_address,
  // entry_strength, entry_last_seen, entry_name, zero pad
  output logic [111:0] out_tdata,
  // status
  output logic [3:0]   out_tuser,
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [2:0]   cfg_index,
  input  logic [31:0]  cfg_data
);

  typedef enum logic [10:0] {
    S_IDLE     = 11'b00000000001,
    S_DECODE   = 11'b00000000010,
    S_SEARCH   = 11'b00000000100,
    S_SORT_KEY = 11'b00000001000,
    S_SORT_LD  = 11'b00000010000,
    S_SORT_CMP = 11'b00000100000,
    S_SORT_PUT = 11'b00001000000,
    S_FIND     = 11'b00010000000,
    S_SHIFT    = 11'b00100000000,
    S_POLL_REF = 11'b01000000000,
    S_READ     = 11'b10000000000
  } state_t;

  // DONE folded: results are loaded from S_POLL_REF, S_READ, etc. through load.
  state_t st_r, st_nxt;

  logic [15:0] min_gap_r;
  logic [9:0]  limit_r;
  logic [7:0]  thin_r;
  logic [31:0] dur_r, intv_r, clr_r, lead_r;

  logic [1:0]  op_r;
  logic [31:0] now_r;
  logic        has_name_r;
  logic [7:0]  len_r;
  logic [39:0] prefix_r;
  logic [47:0] addr_r;
  logic [7:0]  str_r;
  logic [6:0]  idx_r;

  logic [CW-1:0] used_r, used_nxt;
  logic [9:0]    count_r, count_nxt;
  logic [31:0]   last_r, last_nxt;
  logic          open_r, open_nxt;
  logic [31:0]   start_r, start_nxt;
  logic          refresh_r, refresh_nxt;
  logic          rv_r, rv_nxt;
  logic          out_valid_r, out_valid_nxt;

  logic [CW-1:0] ptr_r, ptr_nxt;
  logic [AW-1:0] j_r, j_nxt;
  logic [AW-1:0] raddr_q_r;
  ent_t          key_r, key_nxt;
  logic          by_age_r, by_age_nxt;
  logic [1:0]    nm_r, nm_nxt;
  status_t       res_stat_r, res_stat_nxt;
  logic [AW-1:0] res_pos_r, res_pos_nxt;
  ent_t          res_ent_r, res_ent_nxt;
  logic          done;

  // result load: pending flag set by done, drained into the output register
  logic          pend_r;
  logic          load;

  logic [111:0]  out_tdata_r;
  logic [3:0]    out_tuser_r;

  ent_t          mem [MAX_ENTRIES];
  ent_t          rd_q_r;
  logic [AW-1:0] rd_addr, wa;
  logic          we;
  ent_t          wd;

  logic [31:0]   gap, age, ref_diff, ref_lim;
  logic [9:0]    count_inc;

  assign in_tready  = (st_r == S_IDLE) && !pend_r;
  assign cfg_ready  = 1'b1;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_tdata_r;
  assign out_tuser  = out_tuser_r;

  assign gap       = now_r - last_r;
  assign age       = now_r - start_r;
  assign ref_diff  = now_r - start_r;
  assign ref_lim   = intv_r - lead_r;
  assign count_inc = (count_r == COUNT_MAX) ? count_r : count_r + 10'd1;

  always_comb begin
    st_nxt        = st_r;
    used_nxt      = used_r;
    count_nxt     = count_r;
    last_nxt      = last_r;
    open_nxt      = open_r;
    start_nxt     = start_r;
    refresh_nxt   = refresh_r;
    rv_nxt        = 1'b0;
    ptr_nxt       = ptr_r;
    j_nxt         = j_r;
    key_nxt       = key_r;
    by_age_nxt    = by_age_r;
    nm_nxt        = nm_r;
    res_stat_nxt  = res_stat_r;
    res_pos_nxt   = res_pos_r;
    res_ent_nxt   = res_ent_r;
    done          = 1'b0;
    rd_addr       = '0;
    we            = 1'b0;
    wa            = '0;
    wd            = key_r;
    unique case (st_r)
      S_IDLE: begin
        if (in_tvalid && in_tready) st_nxt = S_DECODE;
      end
      S_DECODE: begin
        res_pos_nxt = '0;
        res_ent_nxt = '0;
        unique case (op_r)
          OP_ADVERT: begin
            count_nxt = count_inc;
            done      = 1'b1;
            priority if (gap < {16'd0, min_gap_r}) begin
              res_stat_nxt = RS_RATE;
            end else begin
              last_nxt = now_r;
              priority if (count_inc > limit_r || 32'(used_r) >= MAX_ENTRIES) begin
                open_nxt     = 1'b0;
                res_stat_nxt = RS_FULL;
              end else if (32'(used_r) > 32'(thin_r) && count_inc[0]) begin
                res_stat_nxt = RS_THINNED;
              end else if (!has_name_r) begin
                res_stat_nxt = RS_NO_NAME;
              end else if (len_r == 8'd0 || len_r >= 8'd32) begin
                res_stat_nxt = RS_BAD_LEN;
              end else if (len_r != 8'd5) begin
                res_stat_nxt = RS_UNKNOWN;
              end else if (prefix_r == NAME_A) begin
                nm_nxt = 2'd0; done = 1'b0; ptr_nxt = '0; st_nxt = S_SEARCH;
              end else if (prefix_r == NAME_B) begin
                nm_nxt = 2'd1; done = 1'b0; ptr_nxt = '0; st_nxt = S_SEARCH;
              end else if (prefix_r == NAME_C) begin
                nm_nxt = 2'd2; done = 1'b0; ptr_nxt = '0; st_nxt = S_SEARCH;
              end else begin
                res_stat_nxt = RS_UNKNOWN;
              end
            end
          end
          OP_POLL: begin
            res_stat_nxt = RS_POLL;
            st_nxt       = S_POLL_REF;
            if (age > clr_r) count_nxt = '0;
            priority if (open_r && age > dur_r) begin
              open_nxt  = 1'b0;
              count_nxt = '0;
              start_nxt = now_r;
            end else if (!open_r && age > intv_r) begin
              open_nxt  = 1'b1;
              count_nxt = '0;
              start_nxt = now_r;
              if (32'(used_r) >= MAX_ENTRIES) begin
                res_stat_nxt = RS_EVICTED;
                by_age_nxt   = 1'b1;
                ptr_nxt      = CW'(1);
                st_nxt       = S_SORT_KEY;
              end
            end else begin
            end
          end
          OP_READ: begin
            if (32'(idx_r) < 32'(used_r)) begin
              rd_addr = AW'(idx_r);
              st_nxt  = S_READ;
            end else begin
              res_stat_nxt = RS_READ_RANGE;
              done         = 1'b1;
            end
          end
          default: begin
            res_stat_nxt = RS_READ_RANGE;
            done         = 1'b1;
          end
        endcase
      end
      S_SEARCH: begin
        priority if (rv_r && rd_q_r.addr == addr_r) begin
          we           = 1'b1;
          wa           = raddr_q_r;
          wd           = '{addr: addr_r, str: str_r, seen: now_r, name: rd_q_r.name};
          res_stat_nxt = RS_UPDATED;
          by_age_nxt   = 1'b0;
          ptr_nxt      = CW'(1);
          st_nxt       = S_SORT_KEY;
        end else if (ptr_r < used_r) begin
          rd_addr = ptr_r[AW-1:0];
          rv_nxt  = 1'b1;
          ptr_nxt = ptr_r + CW'(1);
        end else if (!rv_r) begin
          we           = 1'b1;
          wa           = used_r[AW-1:0];
          wd           = '{addr: addr_r, str: str_r, seen: now_r, name: nm_r};
          used_nxt     = used_r + CW'(1);
          res_stat_nxt = RS_INSERTED;
          by_age_nxt   = 1'b0;
          ptr_nxt      = CW'(1);
          st_nxt       = S_SORT_KEY;
        end else begin
        end
      end
      S_SORT_KEY: begin
        if (ptr_r < used_r) begin
          rd_addr = ptr_r[AW-1:0];
          st_nxt  = S_SORT_LD;
        end else if (by_age_r) begin
          ptr_nxt = CW'(DROP);
          st_nxt  = S_SHIFT;
        end else begin
          ptr_nxt = '0;
          st_nxt  = S_FIND;
        end
      end
      S_SORT_LD: begin
        key_nxt = rd_q_r;
        j_nxt   = ptr_r[AW-1:0];
        rd_addr = ptr_r[AW-1:0] - AW'(1);
        st_nxt  = S_SORT_CMP;
      end
      S_SORT_CMP: begin
        we = 1'b1;
        wa = j_r;
        if (ent_before(key_r, rd_q_r, by_age_r)) begin
          wd    = rd_q_r;
          j_nxt = j_r - AW'(1);
          if (j_r > AW'(1)) rd_addr = j_r - AW'(2);
          else st_nxt = S_SORT_PUT;
        end else begin
          wd      = key_r;
          ptr_nxt = ptr_r + CW'(1);
          st_nxt  = S_SORT_KEY;
        end
      end
      S_SORT_PUT: begin
        we      = 1'b1;
        wa      = j_r;
        wd      = key_r;
        ptr_nxt = ptr_r + CW'(1);
        st_nxt  = S_SORT_KEY;
      end
      S_FIND: begin
        priority if (rv_r && rd_q_r.addr == addr_r) begin
          res_pos_nxt = raddr_q_r;
          res_ent_nxt = rd_q_r;
          done        = 1'b1;
        end else if (ptr_r < used_r) begin
          rd_addr = ptr_r[AW-1:0];
          rv_nxt  = 1'b1;
          ptr_nxt = ptr_r + CW'(1);
        end else if (!rv_r) begin
          done = 1'b1;
        end else begin
        end
      end
      S_SHIFT: begin
        if (rv_r) begin
          we = 1'b1;
          wa = raddr_q_r - AW'(DROP);
          wd = rd_q_r;
        end
        if (ptr_r < used_r) begin
          rd_addr = ptr_r[AW-1:0];
          rv_nxt  = 1'b1;
          ptr_nxt = ptr_r + CW'(1);
        end else if (!rv_r) begin
          used_nxt = used_r - CW'(DROP);
          st_nxt   = S_POLL_REF;
        end
      end
      S_POLL_REF: begin
        if (!open_r && ref_diff > ref_lim) refresh_nxt = 1'b1;
        else if (open_r) refresh_nxt = 1'b0;
        done = 1'b1;
      end
      S_READ: begin
        res_pos_nxt  = raddr_q_r;
        res_ent_nxt  = rd_q_r;
        res_stat_nxt = RS_READ_OK;
        done         = 1'b1;
      end
      default: st_nxt = S_IDLE;
    endcase
    // done sets the pending flag and returns to idle; the state is held while the
    // output register is still full and the result waits to be loaded
    if (done) st_nxt = S_IDLE;
  end

  assign load = pend_r && (!out_valid_r || out_tready);
  assign out_valid_nxt = load ? 1'b1 : (out_valid_r && !out_tready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= S_IDLE;
      used_r      <= '0;
      count_r     <= '0;
      last_r      <= '0;
      open_r      <= 1'b1;
      start_r     <= '0;
      refresh_r   <= 1'b0;
      rv_r        <= 1'b0;
      out_valid_r <= 1'b0;
      pend_r      <= 1'b0;
    end else begin
      st_r        <= (pend_r && !load) ? st_r : st_nxt;
      used_r      <= used_nxt;
      count_r     <= count_nxt;
      last_r      <= last_nxt;
      open_r      <= open_nxt;
      start_r     <= start_nxt;
      refresh_r   <= refresh_nxt;
      rv_r        <= rv_nxt;
      out_valid_r <= out_valid_nxt;
      pend_r      <= (pend_r && !load) || done;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_gap_r <= RST_MIN_GAP;
      limit_r   <= RST_LIMIT;
      thin_r    <= RST_THIN;
      dur_r     <= RST_DURATION;
      intv_r    <= RST_INTERVAL;
      clr_r     <= RST_CLEAR_AGE;
      lead_r    <= RST_LEAD;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_MIN_GAP:   min_gap_r <= cfg_data[15:0];
        CFG_LIMIT:     limit_r   <= cfg_data[9:0];
        CFG_THIN:      thin_r    <= cfg_data[7:0];
        CFG_DURATION:  dur_r     <= cfg_data;
        CFG_INTERVAL:  intv_r    <= cfg_data;
        CFG_CLEAR_AGE: clr_r     <= cfg_data;
        CFG_LEAD:      lead_r    <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      op_r       <= in_tuser;
      now_r      <= in_tdata[31:0];
      has_name_r <= in_tdata[32];
      len_r      <= in_tdata[40:33];
      prefix_r   <= in_tdata[80:41];
      addr_r     <= in_tdata[128:81];
      str_r      <= in_tdata[136:129];
      idx_r      <= in_tdata[143:137];
    end
    ptr_r      <= ptr_nxt;
    j_r        <= j_nxt;
    key_r      <= key_nxt;
    by_age_r   <= by_age_nxt;
    nm_r       <= nm_nxt;
    raddr_q_r  <= rd_addr;
    res_stat_r <= res_stat_nxt;
    res_pos_r  <= res_pos_nxt;
    res_ent_r  <= res_ent_nxt;
    if (load) begin
      out_tuser_r <= res_stat_r;
      out_tdata_r <= {5'd0, res_ent_r.name, res_ent_r.seen, res_ent_r.str, res_ent_r.addr,
                      7'(res_pos_r), refresh_r, open_r, 8'(used_r)};
    end
  end

  // table RAM: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (we) mem[wa] <= wd;
    rd_q_r <= mem[rd_addr];
  end

  a_used_bound: assert property (@(posedge clk) disable iff (!rst_n)
    32'(used_r) <= MAX_ENTRIES)
    else $error("entry count above table size");

  a_shift_full: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == S_SHIFT) |-> (32'(used_r) == MAX_ENTRIES))
    else $error("eviction copy on a table that is not full");

  a_cmp_index: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == S_SORT_CMP) |-> (j_r != '0))
    else $error("sort compare at position zero");

  a_insert_room: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == S_SEARCH) |-> (32'(used_r) < MAX_ENTRIES))
    else $error("address search on a full table");

endmodule
